@@ rtl/touch_tap_detect_transform_macros.svh @@
// Assertion macros for the touch tap detect transform block.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef TOUCH_TAP_DETECT_TRANSFORM_MACROS_SVH
`define TOUCH_TAP_DETECT_TRANSFORM_MACROS_SVH

`ifndef NO_ASSERTIONS

`define TTDT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ttdt assertion failed");

`define TTDT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ttdt assertion failed");

`else

`define TTDT_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`define TTDT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/ttdt_pkg.sv @@
// Package for the touch tap detect transform block: types, register codes
// and fixed constants shared by all RTL files. No dependencies.
package ttdt_pkg;

  localparam int RAW_W      = 12;
  localparam int COORD_W    = 9;
  localparam int TIME_W     = 32;
  localparam int INTERVAL_W = 16;
  localparam int PADDR_W    = 5;
  localparam int PDATA_W    = 32;

  localparam logic [RAW_W-1:0]      RAW_COORD_MAX  = 12'd359;
  localparam logic [COORD_W-1:0]    COORD_MAX      = 9'd359;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd35;

  typedef enum logic [2:0] {
    REG_SWAP_AXES = 3'd0,
    REG_MIRROR_X  = 3'd1,
    REG_MIRROR_Y  = 3'd2,
    REG_ROTATION  = 3'd3,
    REG_POLL_INTV = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_t;

  typedef struct packed {
    logic                  swap_axes;
    logic                  mirror_x;
    logic                  mirror_y;
    rot_t                  rotation;
    logic [INTERVAL_W-1:0] poll_interval_ms;
  } ttdt_cfg_t;

endpackage

@@ rtl/ttdt_if.sv @@
// Valid/ready channel interfaces for poll event requests and tap results.
// Depends on ttdt_pkg for field widths.
interface ttdt_in_if import ttdt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              int_active;
  logic [TIME_W-1:0] now_ms;
  logic              read_ok;
  logic [7:0]        finger_byte;
  logic [7:0]        x_high;
  logic [7:0]        x_low;
  logic [7:0]        y_high;
  logic [7:0]        y_low;

  modport source (output valid, int_active, now_ms, read_ok, finger_byte,
                  x_high, x_low, y_high, y_low, input ready);
  modport sink   (input valid, int_active, now_ms, read_ok, finger_byte,
                  x_high, x_low, y_high, y_low, output ready);
endinterface

interface ttdt_out_if import ttdt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               tap;
  logic [COORD_W-1:0] tap_x;
  logic [COORD_W-1:0] tap_y;

  modport source (output valid, tap, tap_x, tap_y, input ready);
  modport sink   (input valid, tap, tap_x, tap_y, output ready);
endinterface

@@ rtl/ttdt_cfg.sv @@
// APB-style configuration register file for the tap detect transform.
// Depends on ttdt_pkg.
module ttdt_cfg import ttdt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [PDATA_W-1:0] cfg_pwdata,
  output logic [PDATA_W-1:0] cfg_prdata,
  output logic               cfg_pready,
  output ttdt_cfg_t          cfg
);

  ttdt_cfg_t cfg_r;
  ttdt_cfg_t cfg_nxt;
  logic      wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (cfg_paddr[PADDR_W-1:2])
        REG_SWAP_AXES: cfg_nxt.swap_axes        = cfg_pwdata[0];
        REG_MIRROR_X:  cfg_nxt.mirror_x         = cfg_pwdata[0];
        REG_MIRROR_Y:  cfg_nxt.mirror_y         = cfg_pwdata[0];
        REG_ROTATION:  cfg_nxt.rotation         = rot_t'(cfg_pwdata[1:0]);
        REG_POLL_INTV: cfg_nxt.poll_interval_ms = cfg_pwdata[INTERVAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[PADDR_W-1:2])
      REG_SWAP_AXES: cfg_prdata = {{(PDATA_W-1){1'b0}}, cfg_r.swap_axes};
      REG_MIRROR_X:  cfg_prdata = {{(PDATA_W-1){1'b0}}, cfg_r.mirror_x};
      REG_MIRROR_Y:  cfg_prdata = {{(PDATA_W-1){1'b0}}, cfg_r.mirror_y};
      REG_ROTATION:  cfg_prdata = {{(PDATA_W-2){1'b0}}, cfg_r.rotation};
      REG_POLL_INTV: cfg_prdata = {{(PDATA_W-INTERVAL_W){1'b0}}, cfg_r.poll_interval_ms};
      default:       cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.swap_axes        <= 1'b0;
      cfg_r.mirror_x         <= 1'b0;
      cfg_r.mirror_y         <= 1'b0;
      cfg_r.rotation         <= ROT_0;
      cfg_r.poll_interval_ms <= INTERVAL_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ rtl/ttdt_xform.sv @@
// Coordinate transform: decode 12-bit X/Y, swap, mirror, clamp, rotate.
// Pure combinational; depends on ttdt_pkg.
module ttdt_xform import ttdt_pkg::*; (
  input  ttdt_cfg_t          cfg,
  input  logic [3:0]         x_hi_nib,
  input  logic [7:0]         x_low,
  input  logic [3:0]         y_hi_nib,
  input  logic [7:0]         y_low,
  output logic [COORD_W-1:0] tap_x,
  output logic [COORD_W-1:0] tap_y
);

  logic [RAW_W-1:0]   raw_x, raw_y;
  logic [RAW_W-1:0]   sw_x, sw_y;
  logic [RAW_W-1:0]   mx, my;
  logic [COORD_W-1:0] cx, cy;

  assign raw_x = {x_hi_nib, x_low};
  assign raw_y = {y_hi_nib, y_low};
  assign sw_x  = cfg.swap_axes ? raw_y : raw_x;
  assign sw_y  = cfg.swap_axes ? raw_x : raw_y;

  always_comb begin
    mx = sw_x;
    my = sw_y;
    if (cfg.mirror_x) begin
      mx = (sw_x <= RAW_COORD_MAX) ? (RAW_COORD_MAX - sw_x) : '0;
    end
    if (cfg.mirror_y) begin
      my = (sw_y <= RAW_COORD_MAX) ? (RAW_COORD_MAX - sw_y) : '0;
    end
    cx = (mx > RAW_COORD_MAX) ? COORD_MAX : mx[COORD_W-1:0];
    cy = (my > RAW_COORD_MAX) ? COORD_MAX : my[COORD_W-1:0];
  end

  always_comb begin
    unique case (cfg.rotation)
      ROT_0: begin
        tap_x = cx;
        tap_y = cy;
      end
      ROT_90: begin
        tap_x = COORD_MAX - cy;
        tap_y = cx;
      end
      ROT_180: begin
        tap_x = COORD_MAX - cx;
        tap_y = COORD_MAX - cy;
      end
      ROT_270: begin
        tap_x = cy;
        tap_y = COORD_MAX - cx;
      end
    endcase
  end

endmodule

@@ rtl/touch_tap_detect_transform.sv @@
// Touch tap detector and coordinate transform, top level.
// Depends on ttdt_pkg, ttdt_if, ttdt_cfg, ttdt_xform and the assertion macros.
//
// Usage:
//   in_if  : poll event requests (interrupt level, ms timestamp, read flag,
//            five report bytes), accepted when valid and ready are high.
//   out_if : one result per request: tap flag and transformed X/Y
//            (both zero when tap is 0).
//   cfg_*  : APB-style registers; pready is always high, writes land in the
//            access cycle. Write only while the block is idle.
// Path: an accepted request is held in the input register, then its result is
//   written to the result register.
// Throughput: one request per cycle when not stalled; the poll gate, edge detect
//   and transform all resolve between the input and result registers.
// Reset: both stages empty, touched flag and last poll time cleared, registers
//   at their defaults (poll interval 35 ms).
// Stall: while out_if.ready is low the result register holds; one more request
//   is taken into the input register, after which in_if.ready drops.
`include "touch_tap_detect_transform_macros.svh"

module touch_tap_detect_transform import ttdt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  ttdt_in_if.sink            in_if,
  ttdt_out_if.source         out_if,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [PDATA_W-1:0] cfg_pwdata,
  output logic [PDATA_W-1:0] cfg_prdata,
  output logic               cfg_pready
);

  ttdt_cfg_t cfg;

  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_int_r;
  logic [TIME_W-1:0] s1_now_r;
  logic              s1_read_ok_r;
  logic [3:0]        s1_finger_r;
  logic [3:0]        s1_xh_r, s1_yh_r;
  logic [7:0]        s1_xl_r, s1_yl_r;

  logic              was_touched_r, was_touched_nxt;
  logic [TIME_W-1:0] last_poll_r, last_poll_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               tap_r;
  logic [COORD_W-1:0] tap_x_r, tap_y_r;

  logic               in_take, s1_adv;
  logic [TIME_W-1:0]  elapsed;
  logic               too_soon;
  logic               touched;
  logic               tap_nxt;
  logic [COORD_W-1:0] xf_x, xf_y;

  ttdt_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  ttdt_xform u_xform (
    .cfg      (cfg),
    .x_hi_nib (s1_xh_r),
    .x_low    (s1_xl_r),
    .y_hi_nib (s1_yh_r),
    .y_low    (s1_yl_r),
    .tap_x    (xf_x),
    .tap_y    (xf_y)
  );

  assign s1_adv      = s1_valid_r & (~out_valid_r | out_if.ready);
  assign in_if.ready = ~s1_valid_r | s1_adv;
  assign in_take     = in_if.valid & in_if.ready;

  assign elapsed  = s1_now_r - last_poll_r;
  assign too_soon = elapsed < {{(TIME_W-INTERVAL_W){1'b0}}, cfg.poll_interval_ms};
  assign touched  = |s1_finger_r;

  always_comb begin
    was_touched_nxt = was_touched_r;
    last_poll_nxt   = last_poll_r;
    tap_nxt         = 1'b0;
    if (s1_adv) begin
      if (!s1_int_r) begin
        was_touched_nxt = 1'b0;
      end else if (!too_soon) begin
        last_poll_nxt = s1_now_r;
        if (s1_read_ok_r) begin
          was_touched_nxt = touched;
          tap_nxt         = touched & ~was_touched_r;
        end
      end
    end
  end

  assign s1_valid_nxt  = in_take | (s1_valid_r & ~s1_adv);
  assign out_valid_nxt = s1_adv | (out_valid_r & ~out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      was_touched_r <= 1'b0;
      last_poll_r   <= '0;
    end else begin
      s1_valid_r    <= s1_valid_nxt;
      out_valid_r   <= out_valid_nxt;
      was_touched_r <= was_touched_nxt;
      last_poll_r   <= last_poll_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_int_r     <= in_if.int_active;
      s1_now_r     <= in_if.now_ms;
      s1_read_ok_r <= in_if.read_ok;
      s1_finger_r  <= in_if.finger_byte[3:0];
      s1_xh_r      <= in_if.x_high[3:0];
      s1_xl_r      <= in_if.x_low;
      s1_yh_r      <= in_if.y_high[3:0];
      s1_yl_r      <= in_if.y_low;
    end
    if (s1_adv) begin
      tap_r   <= tap_nxt;
      tap_x_r <= tap_nxt ? xf_x : '0;
      tap_y_r <= tap_nxt ? xf_y : '0;
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.tap   = tap_r;
  assign out_if.tap_x = tap_x_r;
  assign out_if.tap_y = tap_y_r;

  `TTDT_ASSERT_IMPL(a_no_tap_zero, clk, rst_n, out_valid_r && !tap_r,
                    tap_x_r == '0 && tap_y_r == '0)
  `TTDT_ASSERT_IMPL(a_coord_range, clk, rst_n, out_valid_r,
                    tap_x_r <= COORD_MAX && tap_y_r <= COORD_MAX)
  `TTDT_ASSERT_NEXT(a_idle_clears, clk, rst_n, s1_adv && !s1_int_r,
                    !was_touched_r && $stable(last_poll_r))
  `TTDT_ASSERT_NEXT(a_tap_state, clk, rst_n, s1_adv && tap_nxt,
                    was_touched_r && last_poll_r == $past(s1_now_r) && tap_r)
  `TTDT_ASSERT_NEXT(a_soon_holds, clk, rst_n, s1_adv && s1_int_r && too_soon,
                    $stable(last_poll_r) && $stable(was_touched_r) && !tap_r)

endmodule

@@ test/touch_tap_detect_transform_tb.sv @@
// Testbench for touch_tap_detect_transform: drives poll event requests and
// APB register writes, predicts tap results and checks them in order.
// Depends on ttdt_pkg, the ttdt_in_if/ttdt_out_if interfaces and the RTL top.
`timescale 1ns / 100ps

module touch_tap_detect_transform_tb import ttdt_pkg::*; ;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 210;
  localparam int HOLD_CYCLES = 80;

  typedef struct packed {
    logic              int_active;
    logic [TIME_W-1:0] now_ms;
    logic              read_ok;
    logic [7:0]        finger_byte;
    logic [7:0]        x_high;
    logic [7:0]        x_low;
    logic [7:0]        y_high;
    logic [7:0]        y_low;
  } poll_t;

  typedef struct packed {
    logic               tap;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } tap_t;

  class tap_scoreboard;
    ttdt_cfg_t         cfg;
    logic              was_touched;
    logic [TIME_W-1:0] last_poll_ms;
    tap_t              expected_taps[$];
    int                errors;

    function new();
      cfg = '0;
      cfg.poll_interval_ms = INTERVAL_RESET;
      was_touched = 1'b0;
      last_poll_ms = '0;
      errors = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [PDATA_W-1:0] v);
      case (idx)
        REG_SWAP_AXES: cfg.swap_axes = v[0];
        REG_MIRROR_X:  cfg.mirror_x = v[0];
        REG_MIRROR_Y:  cfg.mirror_y = v[0];
        REG_ROTATION:  cfg.rotation = rot_t'(v[1:0]);
        REG_POLL_INTV: cfg.poll_interval_ms = v[INTERVAL_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [RAW_W-1:0] mirror(logic [RAW_W-1:0] v);
      return (v <= RAW_COORD_MAX) ? RAW_COORD_MAX - v : '0;
    endfunction

    function logic [COORD_W-1:0] clamp(logic [RAW_W-1:0] v);
      return (v > RAW_COORD_MAX) ? COORD_MAX : v[COORD_W-1:0];
    endfunction

    function tap_t predict_tap(poll_t p);
      tap_t               r;
      logic [TIME_W-1:0]  elapsed;
      logic [TIME_W-1:0]  interval;
      logic               touched;
      logic               rising;
      logic [RAW_W-1:0]   rx;
      logic [RAW_W-1:0]   ry;
      logic [RAW_W-1:0]   t;
      logic [COORD_W-1:0] cx;
      logic [COORD_W-1:0] cy;
      r = '0;
      if (!p.int_active) begin
        was_touched = 1'b0;
        return r;
      end
      elapsed = p.now_ms - last_poll_ms;
      interval = {{(TIME_W-INTERVAL_W){1'b0}}, cfg.poll_interval_ms};
      if (elapsed < interval) return r;
      last_poll_ms = p.now_ms;
      if (!p.read_ok) return r;
      touched = |p.finger_byte[3:0];
      rising = touched && !was_touched;
      was_touched = touched;
      if (!rising) return r;
      rx = {p.x_high[3:0], p.x_low};
      ry = {p.y_high[3:0], p.y_low};
      if (cfg.swap_axes) begin
        t = rx;
        rx = ry;
        ry = t;
      end
      if (cfg.mirror_x) rx = mirror(rx);
      if (cfg.mirror_y) ry = mirror(ry);
      cx = clamp(rx);
      cy = clamp(ry);
      r.tap = 1'b1;
      case (cfg.rotation)
        ROT_90: begin
          r.x = COORD_MAX - cy;
          r.y = cx;
        end
        ROT_180: begin
          r.x = COORD_MAX - cx;
          r.y = COORD_MAX - cy;
        end
        ROT_270: begin
          r.x = cy;
          r.y = COORD_MAX - cx;
        end
        default: begin
          r.x = cx;
          r.y = cy;
        end
      endcase
      return r;
    endfunction

    function void note_poll(poll_t p);
      expected_taps.push_back(predict_tap(p));
    endfunction

    function int pending();
      return expected_taps.size();
    endfunction

    task report(string what);
      errors++;
      if (errors <= 30) $display("MISMATCH at %0t: %s", $time, what);
    endtask

    task check_tap(logic tap, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
      tap_t e;
      if (expected_taps.size() == 0) begin
        report($sformatf("unexpected result tap=%0d x=%0d y=%0d", tap, x, y));
        return;
      end
      e = expected_taps.pop_front();
      if (tap !== e.tap) report($sformatf("tap %0d, expected %0d", tap, e.tap));
      if (x !== e.x) report($sformatf("tap_x %0d, expected %0d", x, e.x));
      if (y !== e.y) report($sformatf("tap_y %0d, expected %0d", y, e.y));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic [PADDR_W-1:0] cfg_paddr;
  logic [PDATA_W-1:0] cfg_pwdata;
  logic [PDATA_W-1:0] cfg_prdata;
  logic               cfg_pready;

  ttdt_in_if  in_ch ();
  ttdt_out_if out_ch ();

  tap_scoreboard     sb;
  logic [TIME_W-1:0] sim_ms;
  int                cur_interval;
  bit                tx_idle_on;
  bit                rx_idle_on;
  bit                hold_request;
  int                stall_cycles;

  touch_tap_detect_transform dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #10 clk = ~clk;

  function automatic poll_t make_poll(logic act, logic [TIME_W-1:0] now, logic ok,
                                      logic [7:0] finger, logic [RAW_W-1:0] xr,
                                      logic [RAW_W-1:0] yr);
    poll_t p;
    p.int_active  = act;
    p.now_ms      = now;
    p.read_ok     = ok;
    p.finger_byte = finger;
    p.x_high      = {4'($urandom), xr[11:8]};
    p.x_low       = xr[7:0];
    p.y_high      = {4'($urandom), yr[11:8]};
    p.y_low       = yr[7:0];
    return p;
  endfunction

  // Mostly polls spaced at or past the interval, with early polls, time
  // jumps (wrap), failed reads and interrupt drops mixed in.
  function automatic poll_t random_poll();
    int               pick;
    logic [7:0]       finger;
    logic [RAW_W-1:0] xr;
    logic [RAW_W-1:0] yr;
    pick = $urandom_range(99);
    if (pick < 60) sim_ms += cur_interval + $urandom_range(20);
    else if (pick < 80) sim_ms += (cur_interval == 0) ? 0 : $urandom_range(cur_interval - 1);
    else if (pick < 90) sim_ms += $urandom;
    finger = 8'($urandom);
    if ($urandom_range(1)) finger[3:0] = 4'h0;
    xr = ($urandom_range(9) < 7) ? RAW_W'($urandom_range(359)) : RAW_W'($urandom);
    yr = ($urandom_range(9) < 7) ? RAW_W'($urandom_range(359)) : RAW_W'($urandom);
    return make_poll($urandom_range(99) < 85, sim_ms, $urandom_range(9) != 0,
                     finger, xr, yr);
  endfunction

  task automatic send_poll(poll_t p);
    while (tx_idle_on && $urandom_range(99) < 24) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid       <= 1'b1;
    in_ch.int_active  <= p.int_active;
    in_ch.now_ms      <= p.now_ms;
    in_ch.read_ok     <= p.read_ok;
    in_ch.finger_byte <= p.finger_byte;
    in_ch.x_high      <= p.x_high;
    in_ch.x_low       <= p.x_low;
    in_ch.y_high      <= p.y_high;
    in_ch.y_low       <= p.y_low;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_poll(p);
  endtask

  task automatic cfg_write(reg_idx_t idx, logic [PDATA_W-1:0] v);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= v;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.write_reg(idx, v);
    if (idx == REG_POLL_INTV) cur_interval = v[INTERVAL_W-1:0];
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_config(logic swap, logic mx, logic my, rot_t rot,
                            logic [INTERVAL_W-1:0] interval);
    cfg_write(REG_SWAP_AXES, {31'd0, swap});
    cfg_write(REG_MIRROR_X, {31'd0, mx});
    cfg_write(REG_MIRROR_Y, {31'd0, my});
    cfg_write(REG_ROTATION, {30'd0, rot});
    cfg_write(REG_POLL_INTV, {16'd0, interval});
  endtask

  // Drop valid and let the pipeline drain before touching registers.
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_ch.ready <= rst_n && !(rx_idle_on && $urandom_range(99) < 24);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_tap(out_ch.tap, out_ch.tap_x, out_ch.tap_y);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.int_active = 1'b0;
    in_ch.now_ms = '0;
    in_ch.read_ok = 1'b0;
    in_ch.finger_byte = '0;
    in_ch.x_high = '0;
    in_ch.x_low = '0;
    in_ch.y_high = '0;
    in_ch.y_low = '0;
    sim_ms = '0;
    cur_interval = INTERVAL_RESET;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    hold_request = 1'b0;
    stall_cycles = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset defaults: early poll after reset, interval gating, failed read,
    // clamping of out-of-range raw values
    send_poll(make_poll(1, 32'd0, 1, 8'h01, 12'd100, 12'd200));
    send_poll(make_poll(0, 32'd10, 1, 8'h01, 12'd100, 12'd200));
    send_poll(make_poll(1, 32'd35, 1, 8'h01, 12'd0, 12'd0));
    send_poll(make_poll(1, 32'd70, 1, 8'h01, 12'd5, 12'd5));
    send_poll(make_poll(1, 32'd80, 1, 8'h00, 12'd5, 12'd5));
    send_poll(make_poll(1, 32'd105, 0, 8'h00, 12'd5, 12'd5));
    send_poll(make_poll(1, 32'd120, 1, 8'h00, 12'd5, 12'd5));
    send_poll(make_poll(1, 32'd140, 1, 8'hF0, 12'd5, 12'd5));
    send_poll(make_poll(1, 32'd175, 1, 8'h0F, 12'd359, 12'hFFF));
    send_poll(make_poll(0, 32'd176, 1, 8'h0F, 12'd1, 12'd1));
    send_poll(make_poll(1, 32'd210, 1, 8'hF1, 12'hFFF, 12'd360));
    wait_drained();

    // zero interval, swap and both mirrors: values past 359 mirror to zero
    set_config(1, 1, 1, ROT_90, 16'd0);
    send_poll(make_poll(0, 32'd0, 0, 8'h00, 12'd0, 12'd0));
    send_poll(make_poll(1, 32'd0, 1, 8'h02, 12'hFFF, 12'd0));
    send_poll(make_poll(0, 32'd0, 1, 8'h02, 12'd0, 12'd0));
    send_poll(make_poll(1, 32'd0, 1, 8'h08, 12'd360, 12'd359));
    send_poll(make_poll(1, 32'd0, 1, 8'h00, 12'd1, 12'd1));
    send_poll(make_poll(1, 32'd0, 1, 8'h04, 12'd359, 12'd360));
    wait_drained();

    // widest interval across the 32-bit time wrap
    set_config(0, 0, 0, ROT_270, 16'hFFFF);
    send_poll(make_poll(1, 32'hFFFF_FFF0, 1, 8'h01, 12'd10, 12'd300));
    send_poll(make_poll(1, 32'h0000_0010, 1, 8'h00, 12'd10, 12'd300));
    send_poll(make_poll(1, 32'h0000_FFEF, 1, 8'h00, 12'd10, 12'd300));
    send_poll(make_poll(0, 32'h0000_FFF0, 1, 8'h00, 12'd10, 12'd300));
    send_poll(make_poll(1, 32'h0001_FFEE, 1, 8'h03, 12'd200, 12'd17));
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: set_config(0, 0, 0, ROT_0, 16'd0);
        1: set_config(1, 1, 1, ROT_270, 16'hFFFF);
        2: set_config(0, 1, 0, ROT_180, INTERVAL_RESET);
        3: set_config(1, 0, 1, ROT_90, 16'd1);
        default: set_config($urandom_range(1), $urandom_range(1), $urandom_range(1),
                            rot_t'($urandom_range(3)),
                            ($urandom_range(3) == 0) ? 16'($urandom) :
                                                       16'($urandom_range(100)));
      endcase
      sim_ms = $urandom;
      tx_idle_on = (ph != 3);
      rx_idle_on = (ph != 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 5 && i == 40) hold_request = 1'b1;
        send_poll(random_poll());
      end
      wait_drained();
    end

    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/ttdt_pkg.sv
rtl/ttdt_if.sv
rtl/ttdt_cfg.sv
rtl/ttdt_xform.sv
rtl/touch_tap_detect_transform.sv
test/touch_tap_detect_transform_tb.sv
